FILE: src/stcr_pkg.sv
`timescale 1ns / 1ps

package stcr_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TABLE_SIZE_W = 9;
  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = TABLE_SIZE_W'(1);

  // register index taken from paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam int COLOR_W = 24;
  localparam int ENTRY_W = 2 * COLOR_W;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       matched;
  } out_beat_t;

endpackage

FILE: src/sorted_table_color_remap_top.sv
`timescale 1ns / 1ps

// Colour remap over a sorted table held in one single-port-read RAM. A load beat
// (kind 0) writes one entry and gives no result; loads to slots at or above
// TABLE_DEPTH are dropped. A pixel beat (kind 1) runs a lower-bound binary search
// over the first table_size entries (clipped to TABLE_DEPTH): the sequencer issues
// one RAM read per probe and uses the registered read data the next cycle to pick
// the next probe. The registered RAM read port sets the pace of the search, and
// the next beat can be accepted in the cycle after the result is registered. in_ready
// is low while a search runs, and the search holds in its last step for as long
// as the previous result still waits unaccepted; one finished result may wait in
// the output register while the next beat is accepted.
// Entries must be loaded in ascending {red, green, blue} key order before use.
module sorted_table_color_remap_top #(
  parameter int TABLE_DEPTH = stcr_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  stcr_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output stcr_pkg::out_beat_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stcr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [stcr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [stcr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = stcr_pkg::TABLE_SIZE_W;

  typedef enum logic [1:0] {
    IDLE,
    PROBE,
    FINAL
  } state_t;

  state_t                         state;
  logic [SW-1:0]                  table_size;
  logic [CW-1:0]                  lo;
  logic [CW-1:0]                  hi;
  logic [CW-1:0]                  mid;
  logic [CW-1:0]                  n;
  logic [stcr_pkg::COLOR_W-1:0]   color;

  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [stcr_pkg::ENTRY_W-1:0]   wr_data;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic [stcr_pkg::ENTRY_W-1:0]   rd_data;

  logic [31:0]                    slot_ext;
  logic [CW-1:0]                  n_next;
  logic [CW-1:0]                  lo_next;
  logic [CW-1:0]                  hi_next;
  logic [CW-1:0]                  mid_next;
  logic [stcr_pkg::COLOR_W-1:0]   key;
  logic                           key_less;
  logic                           hit;
  logic                           in_fire;
  logic                           out_free;
  logic                           cfg_write;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == stcr_pkg::REG_TABLE_SIZE) begin
      prdata = stcr_pkg::CFG_DATA_W'(table_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= stcr_pkg::TABLE_SIZE_RESET;
    end else if (cfg_write && paddr[2] == stcr_pkg::REG_TABLE_SIZE) begin
      table_size <= pwdata[SW-1:0];
    end
  end

  // handshake
  assign in_ready = (state == IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // table write
  assign slot_ext = 32'(in_data.entry_index);
  assign wr_en    = in_fire && (in_data.kind == stcr_pkg::KIND_LOAD) &&
                    (int'(in_data.entry_index) < TABLE_DEPTH);
  assign wr_addr  = slot_ext[AW-1:0];
  assign wr_data  = {in_data.red, in_data.green, in_data.blue,
                     in_data.new_red, in_data.new_green, in_data.new_blue};

  // search step
  assign n_next   = (int'(table_size) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(table_size);
  assign key      = rd_data[stcr_pkg::ENTRY_W-1:stcr_pkg::COLOR_W];
  assign key_less = key < color;
  assign lo_next  = key_less ? mid + CW'(1) : lo;
  assign hi_next  = key_less ? hi : mid;
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);
  assign hit      = (lo < n) && (key == color);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      IDLE: begin
        rd_en   = in_fire && (in_data.kind == stcr_pkg::KIND_PIXEL);
        rd_addr = AW'(n_next >> 1);
      end
      PROBE: begin
        rd_en   = 1'b1;
        rd_addr = (lo_next < hi_next) ? mid_next[AW-1:0] : lo_next[AW-1:0];
      end
      FINAL: begin
        rd_en   = 1'b0;
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  stcr_ram #(
    .WIDTH (stcr_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == FINAL && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_fire && in_data.kind == stcr_pkg::KIND_PIXEL) begin
            color <= {in_data.red, in_data.green, in_data.blue};
            n     <= n_next;
            lo    <= '0;
            hi    <= n_next;
            mid   <= n_next >> 1;
            state <= (n_next != '0) ? PROBE : FINAL;
          end
        end
        PROBE: begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
          if (!(lo_next < hi_next)) begin
            state <= FINAL;
          end
        end
        FINAL: begin
          if (out_free) begin
            out_data.matched   <= hit;
            out_data.out_red   <= hit ? rd_data[23:16] : color[23:16];
            out_data.out_green <= hit ? rd_data[15:8] : color[15:8];
            out_data.out_blue  <= hit ? rd_data[7:0] : color[7:0];
            state              <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/stcr_ram.sv
`timescale 1ns / 1ps

module stcr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
